[rtl/jms_pkg.sv]
package jms_pkg;

    localparam int TABLE_DEPTH_DEF  = 16;
    localparam int OFFSET_WIDTH_DEF = 32;

    localparam logic [7:0] CODE_PREFIX    = 8'hFF;
    localparam logic [7:0] CODE_SOI       = 8'hD8;
    localparam logic [7:0] CODE_EOI       = 8'hD9;
    localparam logic [7:0] CODE_DHT       = 8'hC4;
    localparam logic [7:0] CODE_SOS       = 8'hDA;
    localparam logic [7:0] CODE_DQT       = 8'hDB;
    localparam logic [7:0] CODE_SOF_LO    = 8'hC0;
    localparam logic [7:0] CODE_SOF_HI    = 8'hCF;
    localparam logic [7:0] CODE_JPG       = 8'hC8;
    localparam logic [7:0] CODE_DAC       = 8'hCC;
    localparam logic [7:0] CODE_APP_LO    = 8'hE0;
    localparam logic [7:0] CODE_APP_HI    = 8'hEF;
    localparam logic [7:0] CODE_MARKER_LO = 8'hC0;

    typedef enum logic [2:0] {
        K_SOI          = 3'd0,
        K_EOI_PAIRED   = 3'd1,
        K_EOI_UNPAIRED = 3'd2,
        K_DHT          = 3'd3,
        K_SOF          = 3'd4,
        K_SOS          = 3'd5,
        K_DQT          = 3'd6,
        K_APP          = 3'd7
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_PREFIX   = 4'b0010,
        PH_SOI_FF   = 4'b0100,
        PH_SOI_CODE = 4'b1000
    } t_phase;

    typedef enum logic [0:0] {
        CFG_SCAN_START = 1'b0,
        CFG_SCAN_END   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_dec;

    // control part of a decoded marker on its way to the resolve stage
    typedef struct packed {
        t_kind      kind;
        logic [3:0] subtype;
        logic       full;
        logic       is_eoi;
    } t_s1_ctl;

    function automatic t_dec decode_code(input logic [7:0] code);
        t_dec d;
        d.hit  = 1'b1;
        d.kind = K_SOI;
        if (code == CODE_SOI) begin
            d.kind = K_SOI;
        end else if (code == CODE_EOI) begin
            d.kind = K_EOI_UNPAIRED;
        end else if (code == CODE_DHT) begin
            d.kind = K_DHT;
        end else if ((code inside {[CODE_SOF_LO:CODE_SOF_HI]}) &&
                     code != CODE_JPG && code != CODE_DAC) begin
            d.kind = K_SOF;
        end else if (code == CODE_SOS) begin
            d.kind = K_SOS;
        end else if (code == CODE_DQT) begin
            d.kind = K_DQT;
        end else if (code inside {[CODE_APP_LO:CODE_APP_HI]}) begin
            d.kind = K_APP;
        end else begin
            d.hit = 1'b0;
        end
        return d;
    endfunction

endpackage

[rtl/jms_table.sv]
module jms_table import jms_pkg::*; #(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [OFFSET_WIDTH-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic [OFFSET_WIDTH-1:0] o_rdata
);

    logic [OFFSET_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  r_vld;
    logic [OFFSET_WIDTH-1:0] r_rd_data;
    logic                    r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    // entries never written read as zero (empty)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : '0;

endmodule

[rtl/jms_scan.sv]
module jms_scan import jms_pkg::*; #(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_index,
    input  logic [OFFSET_WIDTH-1:0] i_cfg_data,
    input  logic                    i_valid,
    input  logic [7:0]              i_data_byte,
    output logic                    o_stall,
    input  logic                    i_s1_move,
    output logic                    o_s1_valid,
    output t_s1_ctl                 o_s1_ctl,
    output logic [OFFSET_WIDTH-1:0] o_s1_offset,
    output logic [CW-1:0]           o_s1_open_cnt,
    output logic                    o_wr_en,
    output logic [AW-1:0]           o_wr_addr,
    output logic [OFFSET_WIDTH-1:0] o_wr_data,
    output logic                    o_rd_en
);

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [OFFSET_WIDTH-1:0] SOI_SKIP = OFFSET_WIDTH'(2);

    t_phase                  r_phase, n_phase;
    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;
    logic [OFFSET_WIDTH-1:0] r_end, n_end;
    logic [OFFSET_WIDTH-1:0] r_mpos, n_mpos;
    logic                    r_stopped, n_stopped;
    logic [CW-1:0]           r_open, n_open;
    logic                    r_s1_valid;
    t_s1_ctl                 r_s1_ctl;
    logic [OFFSET_WIDTH-1:0] r_s1_offset;
    logic [CW-1:0]           r_s1_open_cnt;

    logic    accept;
    logic    do_dec;
    t_dec    dec;
    logic    hit;
    logic    full;
    t_s1_ctl s1_ctl;

    assign o_stall = r_s1_valid && !i_s1_move;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_end     = r_end;
        n_mpos    = r_mpos;
        n_stopped = r_stopped;
        n_open    = r_open;
        do_dec    = 1'b0;
        hit       = 1'b0;
        full      = 1'b0;
        o_wr_en   = 1'b0;
        dec       = decode_code(i_data_byte);
        if (accept && !r_stopped) begin
            if (r_pos >= r_end) begin
                n_stopped = 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
                case (r_phase)
                    PH_PREFIX: begin
                        n_phase = PH_IDLE;
                        do_dec  = 1'b1;
                    end
                    PH_SOI_FF: begin
                        if (i_data_byte == CODE_PREFIX) begin
                            n_mpos  = r_pos;
                            n_phase = PH_SOI_CODE;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_SOI_CODE: begin
                        n_phase = PH_IDLE;
                        if (i_data_byte >= CODE_MARKER_LO && i_data_byte != CODE_PREFIX) begin
                            // SOI confirmed; one at offset zero restarts the count
                            if (r_mpos == SOI_SKIP) begin
                                n_open = '0;
                            end else if (r_open < DEPTH_C) begin
                                n_open = r_open + 1'b1;
                            end
                            do_dec = 1'b1;
                        end
                    end
                    default: begin
                        if (i_data_byte == CODE_PREFIX) begin
                            n_mpos  = r_pos;
                            n_phase = PH_PREFIX;
                        end
                    end
                endcase
                if (do_dec && dec.hit) begin
                    hit = 1'b1;
                    if (dec.kind == K_SOI) begin
                        n_phase = PH_SOI_FF;
                        if (n_open < DEPTH_C) begin
                            o_wr_en = 1'b1;
                        end else begin
                            full = 1'b1;
                        end
                    end
                end
            end
        end
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SCAN_START: n_pos = i_cfg_data;
                CFG_SCAN_END:   n_end = i_cfg_data;
                default:        n_end = r_end;
            endcase
        end
    end

    assign o_wr_addr = n_open[AW-1:0];
    assign o_wr_data = r_mpos;
    assign o_rd_en   = accept;

    always_comb begin
        s1_ctl.kind    = dec.kind;
        s1_ctl.subtype = i_data_byte[3:0];
        s1_ctl.full    = full;
        s1_ctl.is_eoi  = (dec.kind == K_EOI_UNPAIRED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pos      <= '0;
            r_end      <= '1;
            r_mpos     <= '0;
            r_stopped  <= 1'b0;
            r_open     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_end     <= n_end;
            r_mpos    <= n_mpos;
            r_stopped <= n_stopped;
            r_open    <= n_open;
            if (accept) begin
                r_s1_valid <= hit;
            end else if (i_s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl      <= s1_ctl;
            r_s1_offset   <= r_mpos;
            r_s1_open_cnt <= n_open;
        end
    end

    assign o_s1_valid    = r_s1_valid;
    assign o_s1_ctl      = r_s1_ctl;
    assign o_s1_offset   = r_s1_offset;
    assign o_s1_open_cnt = r_s1_open_cnt;

endmodule

[rtl/jms_resolve.sv]
module jms_resolve import jms_pkg::*; #(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s1_valid,
    input  t_s1_ctl                 i_s1_ctl,
    input  logic [OFFSET_WIDTH-1:0] i_s1_offset,
    input  logic [CW-1:0]           i_s1_open_cnt,
    output logic                    o_s1_move,
    output logic [AW-1:0]           o_rd_addr,
    input  logic [OFFSET_WIDTH-1:0] i_rd_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output t_kind                   o_kind,
    output logic [3:0]              o_subtype,
    output logic [OFFSET_WIDTH-1:0] o_offset,
    output logic [CW-1:0]           o_open_cnt,
    output logic [CW-1:0]           o_closed_cnt,
    output logic [OFFSET_WIDTH-1:0] o_pair_start,
    output logic                    o_full
);

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [CW-1:0]           r_close;
    logic                    r_out_valid;
    t_kind                   r_out_kind;
    logic [3:0]              r_out_subtype;
    logic [OFFSET_WIDTH-1:0] r_out_offset;
    logic [CW-1:0]           r_out_open;
    logic [CW-1:0]           r_out_closed;
    logic [OFFSET_WIDTH-1:0] r_out_pair;
    logic                    r_out_full;
    logic                    eoi_ok;

    // successive EOIs are two or more bytes apart, so r_close is settled
    // before the next EOI's table read is issued
    assign o_rd_addr = r_close[AW-1:0];
    assign o_s1_move = i_s1_valid && (!r_out_valid || !i_stall);
    assign eoi_ok    = i_s1_ctl.is_eoi && (r_close < DEPTH_C) && (i_rd_data != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s1_move) begin
                r_out_valid <= 1'b1;
                if (eoi_ok) begin
                    r_close <= r_close + 1'b1;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_move) begin
            r_out_kind    <= eoi_ok ? K_EOI_PAIRED : i_s1_ctl.kind;
            r_out_subtype <= i_s1_ctl.subtype;
            r_out_offset  <= i_s1_offset;
            r_out_open    <= i_s1_open_cnt;
            r_out_closed  <= r_close;
            r_out_pair    <= eoi_ok ? i_rd_data : '0;
            r_out_full    <= i_s1_ctl.full;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_subtype    = r_out_subtype;
    assign o_offset     = r_out_offset;
    assign o_open_cnt   = r_out_open;
    assign o_closed_cnt = r_out_closed;
    assign o_pair_start = r_out_pair;
    assign o_full       = r_out_full;

`ifndef SYNTHESIS
    a_close_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_close <= DEPTH_C)
        else $error("close index past table depth");

    a_pair_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == K_EOI_PAIRED |-> r_out_pair != '0)
        else $error("paired EOI with empty start");

    a_pair_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind != K_EOI_PAIRED |-> r_out_pair == '0)
        else $error("pair start on unpaired marker");

    a_full_soi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_full |-> r_out_kind == K_SOI)
        else $error("table full on non-SOI marker");

    a_close_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s1_move && eoi_ok |=> r_close == $past(r_close) + 1'b1)
        else $error("close index not advanced on paired EOI");
`endif

endmodule

[rtl/jpeg_marker_scanner.sv]
// A marker's code byte is registered in the decode stage and then in the output register.
// Throughput: one byte per cycle while o_stall is low; each start-table port (one write,
// one registered read) is used at most once per byte, so the byte stream never waits on it.
// Output register plus a decode stage: the input stalls only while both are full.
// Reset (synchronous, active low): scan idle, offset 0, end offset all ones, counts zero,
// start table empty at once through per-entry valid bits.
module jpeg_marker_scanner import jms_pkg::*; #(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_index,
    input  logic [OFFSET_WIDTH-1:0] i_cfg_data,
    input  logic                    i_valid,
    input  logic [7:0]              i_data_byte,
    output logic                    o_stall,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_marker_kind,
    output logic [3:0]              o_marker_subtype,
    output logic [OFFSET_WIDTH-1:0] o_marker_offset,
    output logic [CW-1:0]           o_open_count,
    output logic [CW-1:0]           o_closed_count,
    output logic [OFFSET_WIDTH-1:0] o_pair_start,
    output logic                    o_table_full
);

    logic                    s1_valid;
    t_s1_ctl                 s1_ctl;
    logic [OFFSET_WIDTH-1:0] s1_offset;
    logic [CW-1:0]           s1_open_cnt;
    logic                    s1_move;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [OFFSET_WIDTH-1:0] wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [OFFSET_WIDTH-1:0] rd_data;
    t_kind                   out_kind;

    jms_scan #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .i_data_byte   (i_data_byte),
        .o_stall       (o_stall),
        .i_s1_move     (s1_move),
        .o_s1_valid    (s1_valid),
        .o_s1_ctl      (s1_ctl),
        .o_s1_offset   (s1_offset),
        .o_s1_open_cnt (s1_open_cnt),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en)
    );

    jms_table #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    jms_resolve #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_resolve (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s1_valid    (s1_valid),
        .i_s1_ctl      (s1_ctl),
        .i_s1_offset   (s1_offset),
        .i_s1_open_cnt (s1_open_cnt),
        .o_s1_move     (s1_move),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (out_kind),
        .o_subtype     (o_marker_subtype),
        .o_offset      (o_marker_offset),
        .o_open_cnt    (o_open_count),
        .o_closed_cnt  (o_closed_count),
        .o_pair_start  (o_pair_start),
        .o_full        (o_table_full)
    );

    assign o_marker_kind = out_kind;

endmodule

[tb/tb_jpeg_marker_scanner.sv]
`timescale 1ns / 1ps

module tb_jpeg_marker_scanner;
    import jms_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 120;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  subtype;
        logic [31:0] offset;
        logic [4:0]  open_count;
        logic [4:0]  closed_count;
        logic [31:0] pair_start;
        logic        full;
    } marker_rec;

    // Tracks the scan state and the SOI start table, queues the markers the block must report.
    class marker_scoreboard;
        logic [31:0] start_off;
        logic [31:0] end_off;
        logic [31:0] byte_pos;
        logic [31:0] mark_pos;
        t_phase      phase;
        bit          stopped;
        logic [31:0] soi_table [DEPTH];
        logic [4:0]  open_cnt;
        logic [4:0]  close_cnt;
        marker_rec   markers_due [$];
        int          errors;
        int          reports;

        function new();
            start_off = '0;
            end_off   = '1;
            byte_pos  = '0;
            mark_pos  = '0;
            phase     = PH_IDLE;
            stopped   = 1'b0;
            foreach (soi_table[i]) soi_table[i] = '0;
            open_cnt  = '0;
            close_cnt = '0;
            errors    = 0;
            reports   = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] val);
            if (idx == CFG_SCAN_START) begin
                start_off = val;
                byte_pos  = val;
            end else begin
                end_off = val;
            end
        endfunction

        function int pending();
            return markers_due.size();
        endfunction

        function void decode_marker(logic [7:0] code);
            marker_rec r;
            r.kind         = K_SOI;
            r.subtype      = code[3:0];
            r.offset       = mark_pos;
            r.open_count   = open_cnt;
            r.closed_count = close_cnt;
            r.pair_start   = '0;
            r.full         = 1'b0;
            if (code == CODE_SOI) begin
                if (open_cnt < DEPTH) begin
                    soi_table[open_cnt] = mark_pos;
                end else begin
                    r.full = 1'b1;
                end
                phase = PH_SOI_FF;
            end else if (code == CODE_EOI) begin
                // zero entry means empty, so an SOI at offset zero never pairs
                if (close_cnt < DEPTH && soi_table[close_cnt] != 32'd0) begin
                    r.kind       = K_EOI_PAIRED;
                    r.pair_start = soi_table[close_cnt];
                    close_cnt    = close_cnt + 5'd1;
                end else begin
                    r.kind = K_EOI_UNPAIRED;
                end
            end else if (code == CODE_DHT) begin
                r.kind = K_DHT;
            end else if (code >= CODE_SOF_LO && code <= CODE_SOF_HI &&
                         code != CODE_JPG && code != CODE_DAC) begin
                r.kind = K_SOF;
            end else if (code == CODE_SOS) begin
                r.kind = K_SOS;
            end else if (code == CODE_DQT) begin
                r.kind = K_DQT;
            end else if (code >= CODE_APP_LO && code <= CODE_APP_HI) begin
                r.kind = K_APP;
            end else begin
                return;
            end
            markers_due.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            logic [31:0] pos;
            pos = byte_pos;
            if (stopped) return;
            if (pos >= end_off) begin
                stopped = 1'b1;
                return;
            end
            byte_pos = pos + 32'd1;
            case (phase)
                PH_PREFIX: begin
                    phase = PH_IDLE;
                    decode_marker(b);
                end
                PH_SOI_FF: begin
                    if (b == CODE_PREFIX) begin
                        mark_pos = pos;
                        phase    = PH_SOI_CODE;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_SOI_CODE: begin
                    phase = PH_IDLE;
                    if (b >= CODE_MARKER_LO && b != CODE_PREFIX) begin
                        if ((mark_pos - 32'd2) == 32'd0) begin
                            open_cnt = '0;
                        end else if (open_cnt < DEPTH) begin
                            open_cnt = open_cnt + 5'd1;
                        end
                        decode_marker(b);
                    end
                end
                default: begin
                    if (b == CODE_PREFIX) begin
                        mark_pos = pos;
                        phase    = PH_PREFIX;
                    end
                end
            endcase
        endfunction

        function void check_marker(marker_rec got);
            marker_rec want;
            bit        bad;
            if (markers_due.size() == 0) begin
                errors++;
                reports++;
                if (reports <= 10) begin
                    $display("unexpected marker kind %0d offset %h", got.kind, got.offset);
                end
                return;
            end
            want = markers_due.pop_front();
            bad = (got.kind !== want.kind) || (got.subtype !== want.subtype) ||
                  (got.offset !== want.offset) || (got.open_count !== want.open_count) ||
                  (got.closed_count !== want.closed_count) ||
                  (got.pair_start !== want.pair_start) || (got.full !== want.full);
            if (bad) begin
                errors++;
                reports++;
                if (reports <= 10) begin
                    $display("marker mismatch at %0t ns", $time);
                    $display("  got : kind %0d sub %h off %h open %0d closed %0d pair %h full %b",
                             got.kind, got.subtype, got.offset, got.open_count,
                             got.closed_count, got.pair_start, got.full);
                    $display("  want: kind %0d sub %h off %h open %0d closed %0d pair %h full %b",
                             want.kind, want.subtype, want.offset, want.open_count,
                             want.closed_count, want.pair_start, want.full);
                end
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [0:0]  i_cfg_index = CFG_SCAN_START;
    logic [31:0] i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_marker_kind;
    logic [3:0]  o_marker_subtype;
    logic [31:0] o_marker_offset;
    logic [4:0]  o_open_count;
    logic [4:0]  o_closed_count;
    logic [31:0] o_pair_start;
    logic        o_table_full;

    marker_scoreboard sb;
    logic [7:0]       byte_q [$];
    int               hold_gen    = 0;
    int               cycle_count = 0;

    jpeg_marker_scanner dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .i_data_byte      (i_data_byte),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_marker_kind    (o_marker_kind),
        .o_marker_subtype (o_marker_subtype),
        .o_marker_offset  (o_marker_offset),
        .o_open_count     (o_open_count),
        .o_closed_count   (o_closed_count),
        .o_pair_start     (o_pair_start),
        .o_table_full     (o_table_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Output side: check accepted markers, stall on a pattern of its own.
    int        hold_seen = 0;
    int        hold_left = 0;
    int        pat_mode  = 0;
    int        pat_left  = 0;
    marker_rec seen;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen.kind         = t_kind'(o_marker_kind);
            seen.subtype      = o_marker_subtype;
            seen.offset       = o_marker_offset;
            seen.open_count   = o_open_count;
            seen.closed_count = o_closed_count;
            seen.pair_start   = o_pair_start;
            seen.full         = o_table_full;
            sb.check_marker(seen);
        end
        if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (pat_left == 0) begin
                pat_mode = $urandom_range(0, 2);
                pat_left = $urandom_range(8, 60);
            end
            pat_left--;
            case (pat_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    function void add_pair(logic [7:0] code);
        byte_q.push_back(CODE_PREFIX);
        byte_q.push_back(code);
    endfunction

    function void add_segment();
        logic [7:0] code;
        case ($urandom_range(0, 6))
            0:       code = CODE_DHT;
            1:       code = CODE_SOS;
            2:       code = CODE_DQT;
            3:       code = 8'(CODE_APP_LO + $urandom_range(0, 15));
            4:       code = 8'(CODE_SOF_LO + $urandom_range(0, 15));
            5:       code = CODE_EOI;
            default: code = 8'($urandom_range(0, 255));
        endcase
        add_pair(code);
        repeat ($urandom_range(0, 5)) byte_q.push_back(8'($urandom_range(0, 8'hFE)));
    endfunction

    function void add_broken();
        case ($urandom_range(0, 6))
            0: begin
                add_pair(CODE_SOI);
                byte_q.push_back(8'($urandom_range(0, 8'hFE)));
            end
            1: begin
                add_pair(CODE_SOI);
                add_pair(8'($urandom_range(0, 8'hBF)));
            end
            2: begin
                add_pair(CODE_SOI);
                add_pair(CODE_PREFIX);
            end
            3: add_pair(CODE_PREFIX);
            4: add_pair(8'($urandom_range(0, 255)));
            5: add_pair(CODE_SOI);
            default: repeat ($urandom_range(1, 8)) byte_q.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    function void add_image();
        add_pair(CODE_SOI);
        if ($urandom_range(0, 9) < 8) begin
            add_pair(8'($urandom_range(CODE_MARKER_LO, 8'hFE)));
            repeat ($urandom_range(0, 3)) add_segment();
            add_pair(CODE_EOI);
        end else begin
            add_broken();
        end
    endfunction

    function void add_unit();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
            add_image();
        end else if (pick < 15) begin
            add_segment();
        end else begin
            add_broken();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_byte(b);
    endtask

    // Sends byte_q in bursts; steady keeps valid high throughout.
    task automatic send_stream(input bit steady);
        int burst;
        burst = 0;
        while (byte_q.size() > 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if (!steady && $urandom_range(0, 3) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
            send_byte(byte_q.pop_front());
            burst--;
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [31:0] start_val, input logic [31:0] end_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SCAN_START;
        i_cfg_data  <= start_val;
        @(posedge i_clk);
        i_cfg_index <= CFG_SCAN_END;
        i_cfg_data  <= end_val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sb.write_reg(CFG_SCAN_START, start_val);
        sb.write_reg(CFG_SCAN_END, end_val);
    endtask

    task automatic run_random(input int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            byte_q.delete();
            repeat ($urandom_range(2, 6)) add_unit();
            sent += byte_q.size();
            send_stream(1'b0);
        end
    endtask

    initial begin
        logic [31:0] base;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_cfg(32'd0, 32'hFFFF_FFFF);

        // SOI at offset zero: confirmation clears the open count, its EOI stays unpaired
        add_pair(CODE_SOI);
        add_pair(CODE_SOF_LO);
        add_pair(CODE_EOI);
        // SOI at a nonzero offset pairs with the next EOI
        add_pair(CODE_SOI);
        add_pair(8'hC2);
        add_pair(CODE_EOI);
        add_pair(CODE_DHT);
        add_pair(CODE_SOS);
        add_pair(CODE_DQT);
        add_pair(CODE_APP_LO);
        add_pair(CODE_APP_HI);
        // SOI follow-ups that never confirm
        add_pair(CODE_SOI);
        byte_q.push_back(8'h00);
        add_pair(CODE_SOI);
        add_pair(8'h10);
        send_stream(1'b0);
        wait_drained();

        base = $urandom() & 32'h7FFF_FFFF;
        write_cfg(base, base + 32'h0010_0000);
        run_random(120);

        // long output hold while the input keeps offering
        hold_gen++;
        byte_q.delete();
        while (byte_q.size() < 80) add_image();
        send_stream(1'b1);
        wait_drained();

        base = 32'h8000_0000 + $urandom_range(0, 32'h7FF0_0000);
        write_cfg(base, 32'hFFFF_FFFF);
        run_random(100);
        wait_drained();

        // run into the last offset; the EOI's code byte is cut and the SOI pairs after it are ignored
        write_cfg(32'hFFFF_FFE0, 32'hFFFF_FFFF);
        byte_q.delete();
        while (byte_q.size() < 24) add_unit();
        while (byte_q.size() > 30) void'(byte_q.pop_back());
        while (byte_q.size() < 30) byte_q.push_back(8'h00);
        add_pair(CODE_EOI);
        repeat (4) add_pair(CODE_SOI);
        send_stream(1'b0);
        wait_drained();

        // stopped scan ignores everything until reset
        write_cfg(32'd0, 32'd0);
        add_image();
        send_stream(1'b0);
        wait_drained();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
